### sv/wio_pkg.sv
// ----------------------------------------------------------------------------
// wio_pkg
// Shared types and constants for the wheel/IMU odometry integrator.
// ----------------------------------------------------------------------------
package wio_pkg;

  localparam logic OP_WHEEL = 1'b0;
  localparam logic OP_IMU   = 1'b1;

  localparam logic signed [33:0] PI_Q29    = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q29 = 34'sd3373259426;
  localparam logic signed [33:0] PI_Q30    = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30  = 34'sh026DD3B6A;
  localparam logic signed [47:0] POS_MAX   = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] POS_MIN   = 48'sh800000000000;

  typedef struct packed {
    logic        operation;
    logic [31:0] delta_right;
    logic [31:0] delta_left;
    logic [31:0] delta_time;
    logic [31:0] yaw_rate_in;
    logic [31:0] stamp_in;
  } item_t;

  typedef struct packed {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [31:0] heading;
    logic [31:0] forward_speed;
    logic [31:0] heading_rate;
    logic [31:0] stamp_out;
    logic        zero_time_fault;
  } result_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;
      5'd2: v = 32'h0FADBAFC;  5'd3: v = 32'h07F56EA6;
      5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
      5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;
      5'd8: v = 32'h003FFFEA;  5'd9: v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF; 5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF; 5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F; 5'd27: v = 32'h00000007;
      5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return signed'({2'b00, v});
  endfunction

endpackage

### sv/wio_front.sv
// ----------------------------------------------------------------------------
// wio_front
// Input side: accepts items, keeps the yaw rate, queues wheel items.
// ----------------------------------------------------------------------------
module wio_front import wio_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        q_valid,
  input  logic        q_take,
  output item_t       q_item
);

  // two-entry queue; operation field reused to carry nothing (wheel only),
  // yaw_rate_in field carries the rate in force for this wheel item
  item_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic [31:0] rate;
  logic       push, pop;
  item_t      entry;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready && (in_item.operation == OP_WHEEL);
  assign pop  = q_take && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_comb begin
    entry = in_item;
    entry.yaw_rate_in = rate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      rate   <= '0;
    end else begin
      if (in_valid && in_ready && in_item.operation == OP_IMU) begin
        rate <= in_item.yaw_rate_in;
      end
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem[wr_ptr] <= entry;
  end

endmodule

### sv/wio_back.sv
// ----------------------------------------------------------------------------
// wio_back
// Execution side: CORDIC, position and heading update, speed divider.
// ----------------------------------------------------------------------------
module wio_back import wio_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_take,
  input  item_t   q_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROT  = 3'd1;
  localparam logic [2:0] S_MULX = 3'd2;
  localparam logic [2:0] S_MULY = 3'd3;
  localparam logic [2:0] S_HEAD = 3'd4;
  localparam logic [2:0] S_WRAP = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  logic [2:0] state;
  logic signed [47:0] pos_e, pos_n;
  logic signed [33:0] head;
  logic signed [33:0] cx, cy, cz;
  logic       neg;
  logic [5:0] step;
  logic signed [32:0] sum;
  logic [31:0] dt, rate, stamp;
  logic signed [66:0] prod;
  logic signed [63:0] hprod;
  logic signed [41:0] hsum;
  // divider
  logic [56:0] quo;
  logic [31:0] rem;
  logic        dneg;
  logic signed [31:0] speed;

  logic signed [33:0] xs, ys, z0;
  logic signed [66:0] pmul;
  logic signed [35:0] pstep;
  logic signed [49:0] pnew;
  logic signed [47:0] psat;
  logic [32:0] rtry;
  logic [32:0] num_abs;
  logic signed [41:0] wmul;

  assign q_take = (state == S_IDLE) && !out_valid;
  assign xs = cx >>> step[4:0];
  assign ys = cy >>> step[4:0];
  assign z0 = head <<< 1;
  assign pmul = sum * (neg ? -cx : cx);
  assign pstep = 36'((prod + 67'sd1073741824) >>> 31);
  assign pnew = 50'(state == S_MULY ? pos_e : pos_n) + 50'(pstep);
  assign psat = (pnew > 50'(POS_MAX)) ? POS_MAX :
                (pnew < 50'(POS_MIN)) ? POS_MIN : pnew[47:0];
  assign rtry = {rem, quo[56]};
  assign num_abs = sum[32] ? 33'(-sum) : 33'(sum);
  assign wmul = 42'(TWO_PI_Q29) <<< (step[3:0] - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pos_e <= '0;
      pos_n <= '0;
      head  <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_take) begin
            sum   <= 33'(signed'(q_item.delta_right)) + 33'(signed'(q_item.delta_left));
            dt    <= q_item.delta_time;
            rate  <= q_item.yaw_rate_in;
            stamp <= q_item.stamp_in;
            cx <= GAIN_Q30;
            cy <= '0;
            step <= '0;
            if (z0 > HALF_PI_Q30) begin
              cz <= z0 - PI_Q30; neg <= 1'b1;
            end else if (z0 < -HALF_PI_Q30) begin
              cz <= z0 + PI_Q30; neg <= 1'b1;
            end else begin
              cz <= z0; neg <= 1'b0;
            end
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (!cz[33]) begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - atan_q30(step[4:0]);
          end else begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + atan_q30(step[4:0]);
          end
          if (step[4:0] == LAST_STEP) state <= S_MULX;
          step <= step + 6'd1;
        end
        S_MULX: begin
          prod <= pmul;
          cx <= neg ? -cy : cy;
          neg <= 1'b0;
          state <= S_MULY;
        end
        S_MULY: begin
          pos_e <= psat;
          prod <= pmul;
          hprod <= signed'(rate) * signed'({1'b0, dt});
          state <= S_HEAD;
        end
        S_HEAD: begin
          pos_n <= psat;
          hsum <= 42'(head) + 42'((hprod + 64'sd4194304) >>> 23);
          step <= 6'd9;
          state <= S_WRAP;
        end
        S_WRAP: begin
          // remove 256, 128, ... 1 turns while staying outside [-pi, pi], then fold once
          if (step != 6'd0) begin
            if (hsum > 42'(PI_Q29) && hsum - wmul > 42'(PI_Q29)) hsum <= hsum - wmul;
            else if (hsum < -42'(PI_Q29) && hsum + wmul < -42'(PI_Q29))
              hsum <= hsum + wmul;
            step <= step - 6'd1;
          end else if (hsum > 42'(PI_Q29)) hsum <= hsum - 42'(TWO_PI_Q29);
          else if (hsum < -42'(PI_Q29)) hsum <= hsum + 42'(TWO_PI_Q29);
          else begin
            head <= hsum[33:0];
            quo <= {1'b0, num_abs, 23'd0};
            rem <= '0;
            dneg <= sum[32];
            step <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rtry >= {1'b0, dt}) begin
            rem <= 32'(rtry - {1'b0, dt});
            quo <= {quo[55:0], 1'b1};
          end else begin
            rem <= rtry[31:0];
            quo <= {quo[55:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == 6'd56) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    if (dt == 32'd0) speed = '0;
    else if (!dneg) speed = (quo > 57'h7FFFFFFF) ? 32'sh7FFFFFFF : quo[31:0];
    else speed = (quo > 57'h80000000) ? 32'sh80000000 : 32'(-quo[31:0]);
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_res.pos_x <= pos_e;
      out_res.pos_y <= pos_n;
      out_res.heading <= head[31:0];
      out_res.forward_speed <= speed;
      out_res.heading_rate <= rate;
      out_res.stamp_out <= stamp;
      out_res.zero_time_fault <= (dt == 32'd0);
    end
  end

endmodule

### sv/wheel_imu_odometry_integrator.sv
// ----------------------------------------------------------------------------
// wheel_imu_odometry_integrator
// Dead-reckoning odometry from wheel travel and IMU yaw rate.
// ----------------------------------------------------------------------------
// IMU items give no result. The back end takes a queued wheel item once
// its output register is empty and raises the result after these steps,
// in order: CORDIC_STEPS rotation steps, the multiplies and heading step
// (S_MULX, S_MULY, S_HEAD), the heading fold (nine steps of 2*pi multiples
// and a final fold when the heading leaves [-pi, pi]), a 57-step restoring
// divider for the speed and one output load.
// The next wheel item starts only after the result is accepted. A two-entry
// queue lets the input keep accepting while the back end works.
module wheel_imu_odometry_integrator import wio_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // delta_right[31:0], delta_left[63:32], delta_time[95:64],
  // yaw_rate_in[127:96], stamp_in[159:128]
  input  logic [159:0] s_tdata,
  input  logic         s_tuser, // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x[47:0], pos_y[95:48], heading[127:96], forward_speed[159:128],
  // heading_rate[191:160], stamp_out[223:192]
  output logic [223:0] m_tdata,
  output logic         m_tuser  // zero_time_fault
);

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_take;

  assign in_item = {s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
                    s_tdata[127:96], s_tdata[159:128]};

  wio_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
    .q_valid, .q_take, .q_item
  );

  wio_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_item,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {res.stamp_out, res.heading_rate, res.forward_speed,
                    res.heading, res.pos_y, res.pos_x};
  assign m_tuser = res.zero_time_fault;

endmodule

### sv/wio_checker.sv
// ----------------------------------------------------------------------------
// wio_checker
// Port-level checks for the odometry integrator.
// ----------------------------------------------------------------------------
module wio_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [159:0] s_tdata,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [223:0] m_tdata,
  input logic         m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[127:96]) <= 32'sd1686629713 &&
                  $signed(m_tdata[127:96]) >= -32'sd1686629713))
    else $error("heading out of range");

  a_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[159:128] == 32'd0)
    else $error("fault with nonzero speed");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result right after reset");

endmodule

bind wheel_imu_odometry_integrator wio_checker u_chk (.*);
